// ----- hdl/swa_pkg.sv -----
// shared constants, types and helpers of the sliding window average block
package swa_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int DATA_W      = 32;
   localparam int WIN_W       = 7;
   localparam int OUT_CNT_W   = 7;
   localparam int PTR_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W       = DATA_W + $clog2(MAX_WINDOW);
   localparam int STEP_W      = $clog2(SUM_W + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
   } swa_entry_type;

   // zero means a window of one, anything above the store depth saturates
   function automatic logic [CNT_W-1:0] eff_limit(input logic [WIN_W-1:0] w);
      logic [CNT_W-1:0] r;
      if (w == '0) begin
         r = CNT_W'(1);
      end else if (int'(w) > MAX_WINDOW) begin
         r = CNT_W'(MAX_WINDOW);
      end else begin
         r = CNT_W'(w);
      end
      return r;
   endfunction

endpackage

// ----- hdl/swa_ram.sv -----
// generic single write port, single read port ram with registered read
module swa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/swa_front.sv -----
// front end: takes requests, updates ring store, running sum and fill count
module swa_front import swa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [WIN_W-1:0]         csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     push_valid,
   input  logic                     push_ready,
   output swa_entry_type            push_entry
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_READ = 4'b0010,
      F_UPD  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type         state_ff, state_in;
   logic [WIN_W-1:0]        window_ff;
   logic [PTR_W-1:0]        wp_ff, wp_in;
   logic [CNT_W-1:0]        held_ff, held_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [DATA_W-1:0] sample_ff;
   logic                    full_ff;
   swa_entry_type           entry_ff;

   logic [CNT_W-1:0]        limit;
   logic [CNT_W:0]          oldest_wide;
   logic [PTR_W-1:0]        oldest;
   logic [DATA_W-1:0]       rd_data;
   logic signed [SUM_W-1:0] drop;
   logic                    ram_wr;

   assign limit = eff_limit(window_ff);

   // slot of the oldest held sample, wrapped around the ring
   always_comb begin
      oldest_wide = (CNT_W+1)'(wp_ff) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(held_ff);
      if (oldest_wide >= (CNT_W+1)'(MAX_WINDOW)) begin
         oldest_wide = oldest_wide - (CNT_W+1)'(MAX_WINDOW);
      end
      oldest = PTR_W'(oldest_wide);
   end

   swa_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_WINDOW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(wp_ff),
      .wr_data(sample_ff),
      .rd_en  (state_ff == F_READ),
      .rd_addr(oldest),
      .rd_data(rd_data)
   );

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_entry = entry_ff;
   assign ram_wr     = (state_ff == F_UPD);

   always_comb begin
      drop = full_ff ? SUM_W'($signed(rd_data)) : '0;
      sum_in  = sum_ff - drop + SUM_W'(sample_ff);
      held_in = full_ff ? held_ff : held_ff + CNT_W'(1);
      if (wp_ff == PTR_W'(MAX_WINDOW - 1)) begin
         wp_in = '0;
      end else begin
         wp_in = wp_ff + PTR_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) state_in = F_READ;
         end
         F_READ: state_in = F_UPD;
         F_UPD:  state_in = F_PUSH;
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         window_ff <= WINDOW_RESET;
         wp_ff     <= '0;
         held_ff   <= '0;
         sum_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == F_UPD) begin
            wp_ff <= wp_in;
         end
         // a window write restarts the window empty
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
            held_ff   <= '0;
            sum_ff    <= '0;
         end else if (state_ff == F_UPD) begin
            held_ff <= held_in;
            sum_ff  <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_sample;
      end
      if (state_ff == F_READ) begin
         full_ff <= (held_ff >= limit);
      end
      if (state_ff == F_UPD) begin
         entry_ff.sum   <= sum_in;
         entry_ff.count <= held_in;
      end
   end

   a_held_in_window: assert property (@(posedge clock) disable iff (reset)
      held_ff <= limit)
      else $error("held count above window");

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (held_ff == '0) && (sum_ff == '0))
      else $error("window write did not restart window");

endmodule

// ----- hdl/swa_queue.sv -----
// short queue of sum and count pairs between front and divider
module swa_queue import swa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  swa_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output swa_entry_type pop_entry
);

   swa_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] fill_ff;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + QCNT_W'(1);
            2'b01:   fill_ff <= fill_ff - QCNT_W'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill above depth");

endmodule

// ----- hdl/swa_div.sv -----
// back end: bit per cycle signed divide of the sum by the count, output register
module swa_div import swa_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  swa_entry_type             pop_entry,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [DATA_W-1:0]  rsp_average,
   output logic [OUT_CNT_W-1:0]      rsp_fill_count
);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_RUN  = 3'b010,
      B_DONE = 3'b100
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [SUM_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        div_ff;
   logic [STEP_W-1:0]       step_ff;
   logic                    neg_ff;
   logic                    rsp_valid_ff;
   logic signed [DATA_W-1:0] avg_ff;
   logic [OUT_CNT_W-1:0]    cnt_out_ff;

   logic [CNT_W:0]          rem_sh;
   logic                    qbit;
   logic [SUM_W-1:0]        mag_in;
   logic [SUM_W-1:0]        signed_quo;
   logic                    out_free;

   assign pop_ready      = (state_ff == B_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = avg_ff;
   assign rsp_fill_count = cnt_out_ff;

   // magnitude of the dividend, quotient sign restored at the end
   assign mag_in     = pop_entry.sum[SUM_W-1] ? SUM_W'(-pop_entry.sum) : SUM_W'(pop_entry.sum);
   assign signed_quo = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;

   // restoring step
   always_comb begin
      rem_sh = {rem_ff, quo_ff[SUM_W-1]};
      qbit   = (rem_sh >= {1'b0, div_ff});
      rem_in = qbit ? CNT_W'(rem_sh - {1'b0, div_ff}) : CNT_W'(rem_sh);
      quo_in = {quo_ff[SUM_W-2:0], qbit};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid) state_in = B_RUN;
         end
         B_RUN: begin
            if (step_ff == STEP_W'(1)) state_in = B_DONE;
         end
         B_DONE: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (state_ff == B_IDLE && pop_valid) begin
         step_ff <= STEP_W'(SUM_W);
      end else if (state_ff == B_RUN) begin
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && pop_valid) begin
         quo_ff <= mag_in;
         rem_ff <= '0;
         div_ff <= pop_entry.count;
         neg_ff <= pop_entry.sum[SUM_W-1];
      end else if (state_ff == B_RUN) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (state_ff == B_DONE && out_free) begin
         avg_ff     <= DATA_W'(signed_quo);
         cnt_out_ff <= OUT_CNT_W'(div_ff);
      end
   end

   a_run_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN) |-> (step_ff != '0))
      else $error("divider running with no steps left");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DONE) && out_free |=> rsp_valid_ff && (state_ff == B_IDLE))
      else $error("finished quotient not moved to output");

endmodule

// ----- hdl/sliding_window_average_top.sv -----
// top level of the sliding window average block
//
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_ready   req_sample
//  rsp_      out        rsp_valid / rsp_ready   rsp_average, rsp_fill_count
//  csr_      in         csr_wr_en               csr_wr_data (window size)
//
// a taken request goes through the front end's read, update and push states into the queue,
// is loaded into the divider, takes one restoring step per sum bit and is then registered
// neither stage takes new work before the last is done; the slower divider sets the rate
// the two-entry queue lets the front end take the next request while a divide runs
// a waiting result in the output register stalls the divider; the front end goes on until
// the queue is full; reset is synchronous, window size returns to 8, the window starts empty
module sliding_window_average_top import swa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [WIN_W-1:0]         csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_average,
   output logic [OUT_CNT_W-1:0]     rsp_fill_count
);

   logic          push_valid;
   logic          push_ready;
   swa_entry_type push_entry;
   logic          pop_valid;
   logic          pop_ready;
   swa_entry_type pop_entry;

   swa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   swa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry)
   );

   swa_div u_div (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_entry     (pop_entry),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_average   (rsp_average),
      .rsp_fill_count(rsp_fill_count)
   );

endmodule
